// ----- hdl/i2cee_pkg.sv -----
`default_nettype none

package i2cee_pkg;

  // Bus event codes carried on the command field.
  localparam logic [2:0] CMD_ADDR_READ  = 3'd0;
  localparam logic [2:0] CMD_ADDR_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ_DATA  = 3'd2;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;

  // Reset value of the ignored-byte register.
  localparam logic [7:0] IGNORED_RESET = 8'd80;

  // Memory location that holds the page byte for upper-half addresses.
  localparam int unsigned PAGE_LOCATION = 127;

  // Width of a computed address before the range check (rx + 128 * page).
  localparam int unsigned ADDR_WIDTH = 16;

  // Number of bytes covered by the identification image.
  localparam int unsigned IMAGE_BYTES = 256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;   // write the image byte at the pointer during the fill pass
    logic mem_wr;    // store the received byte at the pointer
    logic mem_rd;    // read the byte at the pointer into the read register
    logic ptr_adv;   // advance the pointer, wrapping at the memory size
    logic ptr_set;   // load the pointer from the received address byte
    logic we_set;
    logic we_clr;
    logic ea_set;
    logic ea_clr;
    logic out_load;  // move the read register into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_last;  // pointer is at the last memory location
    logic rx_ok;     // write enabled and the received byte is not ignored
    logic addr_pend; // next accepted byte is an address
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

  // Identification image; every location not listed holds zero.
  function automatic logic [7:0] id_image(input logic [7:0] idx);
    logic [7:0] val;
    begin
      case (idx)
        8'd0:   val = 8'd17;
        8'd1:   val = 8'd5;
        8'd2:   val = 8'd6;
        8'd110: val = 8'd56;
        8'd128: val = 8'd17;
        8'd130: val = 8'd35;
        8'd131: val = 8'd128;
        8'd133: val = 8'd112;
        8'd146: val = 8'd1;
        8'd147: val = 8'd8;
        8'd148: val = 8'd70;
        8'd149: val = 8'd73;
        8'd150: val = 8'd84;
        8'd151: val = 8'd32;
        8'd164: val = 8'd31;
        8'd166: val = 8'd9;
        8'd167: val = 8'd58;
        8'd168: val = 8'd49;
        8'd169: val = 8'd48;
        8'd170: val = 8'd48;
        8'd171: val = 8'd50;
        8'd172: val = 8'd57;
        8'd173: val = 8'd55;
        8'd174: val = 8'd49;
        8'd175: val = 8'd49;
        8'd176: val = 8'd48;
        8'd177: val = 8'd49;
        8'd178, 8'd179, 8'd180, 8'd181, 8'd182, 8'd183: val = 8'd32;
        8'd184: val = 8'd49;
        8'd185: val = 8'd32;
        8'd186: val = 8'd66;
        8'd187: val = 8'd104;
        8'd188: val = 8'd7;
        8'd189: val = 8'd208;
        8'd191: val = 8'd99;
        8'd192: val = 8'd2;
        8'd196: val = 8'd53;
        8'd197: val = 8'd50;
        8'd198: val = 8'd56;
        8'd199: val = 8'd54;
        8'd200: val = 8'd50;
        8'd201: val = 8'd48;
        8'd202: val = 8'd55;
        8'd203: val = 8'd53;
        8'd204: val = 8'd48;
        8'd205, 8'd206, 8'd207, 8'd208, 8'd209: val = 8'd32;
        8'd210, 8'd211, 8'd212: val = 8'd32;
        8'd213: val = 8'd49;
        8'd214: val = 8'd53;
        8'd215: val = 8'd49;
        8'd216: val = 8'd48;
        8'd217: val = 8'd49;
        8'd218: val = 8'd51;
        8'd219: val = 8'd32;
        8'd220: val = 8'd32;
        8'd224: val = 8'd41;
        default: val = 8'd0;
      endcase
      return val;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/i2c_target_eeprom_emulator.sv -----
// I2C EEPROM target emulator. Each input beat is one bus event (address-read,
// address-write, read-data with a NACK flag, received byte, or stop); read
// events give one output beat (none on NACK) with the byte at the pointer,
// which then advances and wraps at MEM_BYTES. After an address-write, the
// first accepted received byte sets the pointer (bytes of 128 and up are
// extended by 128 times the page byte at location 127; addresses past the
// memory give 0), later bytes are stored. Bytes equal to the ignored-byte
// register are dropped. After reset the block fills its memory with the
// identification image, one byte per cycle, and holds in_stall_o high
// meanwhile; configuration writes are taken at any time. Read events pass
// through a memory read, then an output register load, which waits while
// the output register is full and stalled; all other events are handled
// in the idle state alone. The output register lets a new event be taken
// while a result waits.
`default_nettype none

module i2c_target_eeprom_emulator #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] ignored_byte_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       nack_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o
);

  import i2cee_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_sts;

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  i2cee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .nack_i     (nack_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  i2cee_dpath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .ignored_byte_i (ignored_byte_i),
    .rx_byte_i      (rx_byte_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .read_data_o    (read_data_o),
    .cmd_i          (ctrl_cmd),
    .sts_o          (dp_sts)
  );

endmodule

`default_nettype wire

// ----- hdl/i2cee_ctrl.sv -----
`default_nettype none

module i2cee_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [2:0]           cmd_i,
  input  wire logic                 nack_i,
  output logic                      in_stall_o,
  input  wire i2cee_pkg::dp_status_t sts_i,
  output i2cee_pkg::ctrl_cmd_t      cmd_o
);

  import i2cee_pkg::*;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = stall_q;

  // Fill pass, event decode into datapath commands, output load, next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.ptr_adv = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_ADDR_READ: begin
              cmd_o.mem_rd  = 1'b1;
              cmd_o.ptr_adv = 1'b1;
              cmd_o.we_clr  = 1'b1;
              state_d       = ST_READ;
            end
            CMD_ADDR_WRITE: begin
              cmd_o.we_set = 1'b1;
              cmd_o.ea_set = 1'b1;
            end
            CMD_READ_DATA: begin
              if (!nack_i) begin
                cmd_o.mem_rd  = 1'b1;
                cmd_o.ptr_adv = 1'b1;
                state_d       = ST_READ;
              end
            end
            CMD_RX_BYTE: begin
              if (sts_i.rx_ok) begin
                if (sts_i.addr_pend) begin
                  cmd_o.ptr_set = 1'b1;
                end else begin
                  cmd_o.mem_wr  = 1'b1;
                  cmd_o.ptr_adv = 1'b1;
                end
                cmd_o.ea_clr = 1'b1;
              end
            end
            default: begin
              // Stop and unused codes leave the state alone.
            end
          endcase
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign stall_d = (state_d != ST_IDLE);

  // State and the registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2cee_dpath.sv -----
`default_nettype none

module i2cee_dpath #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [7:0]            ignored_byte_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [7:0]                 read_data_o,
  input  wire i2cee_pkg::ctrl_cmd_t  cmd_i,
  output i2cee_pkg::dp_status_t      sts_o
);

  import i2cee_pkg::*;

  localparam int unsigned PW = $clog2(MEM_BYTES);
  localparam logic [PW-1:0] PTR_LAST = PW'(MEM_BYTES - 1);
  localparam logic [PW-1:0] PTR_PAGE = PW'(PAGE_LOCATION);
  localparam logic [ADDR_WIDTH-1:0] MEM_LIMIT = ADDR_WIDTH'(MEM_BYTES);
  localparam logic [ADDR_WIDTH-1:0] IMAGE_LIMIT = ADDR_WIDTH'(IMAGE_BYTES);

  logic [7:0]            mem_q [MEM_BYTES];
  logic [7:0]            rdata_q;
  logic [PW-1:0]         ptr_q, ptr_d, ptr_next;
  logic                  we_q, we_d;
  logic                  ea_q, ea_d;
  logic [7:0]            ign_q;
  logic [7:0]            page_q;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            read_data_q;
  logic [ADDR_WIDTH-1:0] ptr_ext;
  logic [ADDR_WIDTH-1:0] addr;
  logic [7:0]            init_byte;
  logic [7:0]            wdata;
  logic                  mem_we;

  // Fill pass data: image bytes, then zero beyond the image.
  assign ptr_ext   = ADDR_WIDTH'(ptr_q);
  assign init_byte = (ptr_ext < IMAGE_LIMIT) ? id_image(ptr_ext[7:0]) : 8'd0;
  assign wdata     = cmd_i.init_wr ? init_byte : rx_byte_i;
  assign mem_we    = cmd_i.init_wr || cmd_i.mem_wr;

  // Address byte: the upper half is extended by 128 times the page byte.
  assign addr = ADDR_WIDTH'(rx_byte_i) +
                (rx_byte_i[7] ? (ADDR_WIDTH'(page_q) << 7) : '0);

  assign ptr_next = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

  // Pointer and flag updates.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_set) begin
      ptr_d = (addr < MEM_LIMIT) ? addr[PW-1:0] : '0;
    end else if (cmd_i.ptr_adv) begin
      ptr_d = ptr_next;
    end
    we_d = cmd_i.we_set ? 1'b1 : (cmd_i.we_clr ? 1'b0 : we_q);
    ea_d = cmd_i.ea_set ? 1'b1 : (cmd_i.ea_clr ? 1'b0 : ea_q);
  end

  // Output register drains when the consumer takes the beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      we_q        <= 1'b0;
      ea_q        <= 1'b0;
      ign_q       <= IGNORED_RESET;
      page_q      <= id_image(8'(PAGE_LOCATION));
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      we_q        <= we_d;
      ea_q        <= ea_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        ign_q <= ignored_byte_i;
      end
      // Shadow copy of the page byte, kept in step with its memory location.
      if (mem_we && (ptr_q == PTR_PAGE)) begin
        page_q <= wdata;
      end
    end
  end

  // Byte memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[ptr_q];
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_data_q <= rdata_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  assign sts_o.ptr_last  = (ptr_q == PTR_LAST);
  assign sts_o.rx_ok     = we_q && (rx_byte_i != ign_q);
  assign sts_o.addr_pend = ea_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- verif/i2c_target_eeprom_emulator_checker.sv -----
`timescale 1ns / 1ps

module i2c_target_eeprom_emulator_checker #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_ready_i,
  input  wire logic [7:0] ignored_byte_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       nack_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] read_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o
);

  import i2cee_pkg::*;

  // Addresses from this value up are extended by the page byte.
  localparam int unsigned UPPER_HALF = 128;

  // Nonzero bytes of the identification image as {location, value}.
  // The two runs of space characters are filled in separately.
  localparam int unsigned IMAGE_ENTRIES = 53;
  localparam logic [15:0] IMAGE_SPARSE [IMAGE_ENTRIES] = '{
    {8'd0, 8'd17}, {8'd1, 8'd5}, {8'd2, 8'd6}, {8'd110, 8'd56},
    {8'd128, 8'd17}, {8'd130, 8'd35}, {8'd131, 8'd128}, {8'd133, 8'd112},
    {8'd146, 8'd1}, {8'd147, 8'd8}, {8'd148, 8'd70}, {8'd149, 8'd73},
    {8'd150, 8'd84}, {8'd151, 8'd32},
    {8'd164, 8'd31}, {8'd166, 8'd9}, {8'd167, 8'd58}, {8'd168, 8'd49},
    {8'd169, 8'd48}, {8'd170, 8'd48}, {8'd171, 8'd50}, {8'd172, 8'd57},
    {8'd173, 8'd55}, {8'd174, 8'd49}, {8'd175, 8'd49}, {8'd176, 8'd48},
    {8'd177, 8'd49},
    {8'd184, 8'd49}, {8'd185, 8'd32}, {8'd186, 8'd66}, {8'd187, 8'd104},
    {8'd188, 8'd7}, {8'd189, 8'd208}, {8'd191, 8'd99}, {8'd192, 8'd2},
    {8'd196, 8'd53}, {8'd197, 8'd50}, {8'd198, 8'd56}, {8'd199, 8'd54},
    {8'd200, 8'd50}, {8'd201, 8'd48}, {8'd202, 8'd55}, {8'd203, 8'd53},
    {8'd204, 8'd48},
    {8'd213, 8'd49}, {8'd214, 8'd53}, {8'd215, 8'd49}, {8'd216, 8'd48},
    {8'd217, 8'd49}, {8'd218, 8'd51}, {8'd219, 8'd32}, {8'd220, 8'd32},
    {8'd224, 8'd41}
  };

  // Shadow copy of the emulated EEPROM.
  logic [7:0]  eeprom_shadow [MEM_BYTES];
  int unsigned byte_pointer;
  logic        writes_allowed;
  logic        address_next;
  logic [7:0]  skip_value;

  // Bytes the target should transmit, oldest first.
  logic [7:0]  tx_bytes_due [$];

  function automatic logic [7:0] image_byte(input int unsigned loc);
    logic [7:0] val;
    val = 8'd0;
    if ((loc >= 178 && loc <= 183) || (loc >= 205 && loc <= 212)) begin
      val = 8'd32;
    end
    foreach (IMAGE_SPARSE[k]) begin
      if (IMAGE_SPARSE[k][15:8] == loc) begin
        val = IMAGE_SPARSE[k][7:0];
      end
    end
    return val;
  endfunction

  function automatic int unsigned wrap_next(input int unsigned p);
    return (p + 1 >= MEM_BYTES) ? 0 : p + 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned target;
    if (!rst_ni) begin
      for (int i = 0; i < MEM_BYTES; i++) begin
        eeprom_shadow[i] = (i < IMAGE_BYTES) ? image_byte(i) : 8'd0;
      end
      byte_pointer   = 0;
      writes_allowed = 1'b0;
      address_next   = 1'b0;
      skip_value     = IGNORED_RESET;
      tx_bytes_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Register write from the configuration channel.
      if (cfg_valid_i && cfg_ready_i) begin
        skip_value = ignored_byte_i;
      end

      // Compare an outgoing beat with the oldest byte due.
      if (out_valid_i && !out_stall_i) begin
        if (tx_bytes_due.size() == 0) begin
          $display("%0t: read_data expected none, actual 0x%02h",
                   $time, read_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (read_data_i !== tx_bytes_due[0]) begin
            $display("%0t: read_data expected 0x%02h, actual 0x%02h",
                     $time, tx_bytes_due[0], read_data_i);
            fail_count_o <= fail_count_o + 1;
          end
          void'(tx_bytes_due.pop_front());
          checked_o <= checked_o + 1;
        end
      end

      // Apply an accepted bus event to the shadow state.
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          CMD_ADDR_READ: begin
            tx_bytes_due.push_back(eeprom_shadow[byte_pointer]);
            byte_pointer   = wrap_next(byte_pointer);
            writes_allowed = 1'b0;
          end
          CMD_ADDR_WRITE: begin
            writes_allowed = 1'b1;
            address_next   = 1'b1;
          end
          CMD_READ_DATA: begin
            if (!nack_i) begin
              tx_bytes_due.push_back(eeprom_shadow[byte_pointer]);
              byte_pointer = wrap_next(byte_pointer);
            end
          end
          CMD_RX_BYTE: begin
            if (writes_allowed && rx_byte_i != skip_value) begin
              if (address_next) begin
                // Upper-half addresses select a page through location 127.
                target = rx_byte_i;
                if (rx_byte_i >= UPPER_HALF) begin
                  target += UPPER_HALF * eeprom_shadow[PAGE_LOCATION % MEM_BYTES];
                end
                byte_pointer = (target < MEM_BYTES) ? target : 0;
              end else begin
                eeprom_shadow[byte_pointer] = rx_byte_i;
                byte_pointer = wrap_next(byte_pointer);
              end
              address_next = 1'b0;
            end
          end
          CMD_STOP: begin
          end
          default: begin
          end
        endcase
      end

      pending_o <= tx_bytes_due.size();
    end
  end

endmodule

// ----- verif/i2c_target_eeprom_emulator_test.sv -----
`timescale 1ns / 1ps

module i2c_target_eeprom_emulator_test;

  import i2cee_pkg::*;

  localparam int unsigned MEM_BYTES   = 256;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 8;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [7:0] ignored_byte = IGNORED_RESET;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [2:0] cmd          = CMD_STOP;
  logic [7:0] rx_byte      = 8'd0;
  logic       nack         = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] read_data;

  int fail_count;
  int reads_pending;
  int reads_checked;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int events_sent = 0;
  int settings_written = 0;
  int cycle_count = 0;
  logic [7:0] skip_now = IGNORED_RESET;

  i2c_target_eeprom_emulator #(
    .MEM_BYTES(MEM_BYTES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .ignored_byte_i(ignored_byte),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .rx_byte_i     (rx_byte),
    .nack_i        (nack),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data)
  );

  i2c_target_eeprom_emulator_checker #(
    .MEM_BYTES(MEM_BYTES)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .ignored_byte_i(ignored_byte),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .rx_byte_i     (rx_byte),
    .nack_i        (nack),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_i   (read_data),
    .fail_count_o  (fail_count),
    .pending_o     (reads_pending),
    .checked_o     (reads_checked)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver back-pressure on the read-data channel.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_target_eeprom_emulator_test failed");
      $finish;
    end
  end

  // Present one bus event and hold it until the target takes the beat.
  task automatic send_event(input logic [2:0] c, input logic [7:0] b, input logic n);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    nack     <= n;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    events_sent++;
  endtask

  // Hold off the sender until every read byte has come back.
  task automatic drain_reads();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (reads_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Change the ignored-byte register once the target is quiet.
  task automatic set_skip_byte(input logic [7:0] v);
    drain_reads();
    cfg_valid    <= 1'b1;
    ignored_byte <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    skip_now = v;
    settings_written++;
  endtask

  initial begin
    int          pick;
    int          goal;
    int          burst;
    logic [7:0]  addr_byte;
    logic [7:0]  data_byte;
    logic [7:0]  skip_pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events with the ignored byte at its reset value.
    send_event(CMD_ADDR_READ, 8'h00, 1'b0);
    send_event(CMD_READ_DATA, 8'hFF, 1'b0);
    send_event(CMD_READ_DATA, 8'h00, 1'b1);
    // A received byte with writes not enabled is dropped.
    send_event(CMD_RX_BYTE, 8'hFF, 1'b1);
    // The ignored value is skipped while an address is still due.
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, IGNORED_RESET, 1'b0);
    send_event(CMD_RX_BYTE, 8'hFF, 1'b0);
    send_event(CMD_RX_BYTE, 8'hA5, 1'b0);
    // Read back the top location, then wrap to zero.
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, 8'hFF, 1'b0);
    send_event(CMD_ADDR_READ, 8'h00, 1'b0);
    send_event(CMD_READ_DATA, 8'h00, 1'b0);
    // Set the page byte to one; an upper-half address then lands past the end.
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, 8'd127, 1'b0);
    send_event(CMD_RX_BYTE, 8'd1, 1'b0);
    send_event(CMD_STOP, 8'h00, 1'b0);
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, 8'd130, 1'b0);
    send_event(CMD_READ_DATA, 8'h00, 1'b0);
    send_event(3'd7, 8'h5A, 1'b1);
    // Back to page zero and read the first upper-half byte.
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, 8'd127, 1'b0);
    send_event(CMD_RX_BYTE, 8'd0, 1'b0);
    send_event(CMD_ADDR_WRITE, 8'h00, 1'b0);
    send_event(CMD_RX_BYTE, 8'd128, 1'b0);
    send_event(CMD_ADDR_READ, 8'h00, 1'b0);

    // Random transactions over several register settings and flow patterns.
    for (int chunk = 0; chunk < 8; chunk++) begin
      case (chunk % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      case (chunk)
        0, 6:    skip_pick = 8'd0;
        1, 5:    skip_pick = 8'd255;
        3:       skip_pick = IGNORED_RESET;
        default: skip_pick = 8'($urandom_range(255));
      endcase
      set_skip_byte(skip_pick);

      goal = events_sent + 56;
      while (events_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          // Write transaction: address byte, a few data bytes, stop.
          send_event(CMD_ADDR_WRITE, 8'($urandom), 1'($urandom));
          case ($urandom_range(9))
            0:       addr_byte = skip_now;
            1:       addr_byte = 8'(PAGE_LOCATION);
            default: addr_byte = 8'($urandom);
          endcase
          send_event(CMD_RX_BYTE, addr_byte, 1'($urandom));
          burst = $urandom_range(4);
          for (int k = 0; k < burst; k++) begin
            if ($urandom_range(7) == 0) begin
              data_byte = skip_now;
            end else if (addr_byte == 8'(PAGE_LOCATION) && k == 0) begin
              data_byte = 8'($urandom_range(2));
            end else begin
              data_byte = 8'($urandom);
            end
            send_event(CMD_RX_BYTE, data_byte, 1'($urandom));
          end
          send_event(CMD_STOP, 8'($urandom), 1'($urandom));
        end else if (pick < 80) begin
          // Read transaction, with or without a preceding address set.
          if ($urandom_range(1) == 1) begin
            send_event(CMD_ADDR_WRITE, 8'($urandom), 1'($urandom));
            send_event(CMD_RX_BYTE, 8'($urandom), 1'($urandom));
          end
          send_event(CMD_ADDR_READ, 8'($urandom), 1'($urandom));
          burst = $urandom_range(5);
          for (int k = 0; k < burst; k++) begin
            send_event(CMD_READ_DATA, 8'($urandom), 1'b0);
          end
          send_event(CMD_READ_DATA, 8'($urandom), 1'b1);
          send_event(CMD_STOP, 8'($urandom), 1'($urandom));
        end else if (pick < 96) begin
          // Stray event with any code, including the unused ones.
          send_event(3'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          drain_reads();
        end
      end
    end

    drain_reads();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d bus events and %0d compared read bytes,",
             events_sent, reads_checked);
    $display("with %0d ignored-byte settings and four sender/receiver pacing mixes.",
             settings_written);
    if (fail_count == 0) begin
      $display("i2c_target_eeprom_emulator_test passed");
    end else begin
      $display("i2c_target_eeprom_emulator_test failed");
    end
    $finish;
  end

endmodule
